// ===== hdl/gba_pkg.sv =====
// Shared types and constants for the grouped bitmap allocator.
// No dependencies; imported by the interfaces and every module.
`default_nettype none

package gba_pkg;

  // Default sizing of the item store
  localparam int GROUPS_DEF       = 16;
  localparam int BITMAP_BYTES_DEF = 1024;

  // Item field widths
  localparam int FUNC_W  = 2;
  localparam int GROUP_W = 4;
  localparam int BIDX_W  = 10;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 18;
  localparam int INDEX_W = 18;

  // Register widths
  localparam int GIU_W    = 5;
  localparam int IPG_W    = 14;
  localparam int OFFSET_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // Counter widths
  localparam int GFREE_W = 14;
  localparam int TFREE_W = 18;
  localparam logic [GFREE_W-1:0] GROUP_FREE_MAX = 14'h3fff;
  localparam logic [BYTE_W-1:0]  BYTE_FULL      = 8'hff;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_BYTE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_GROUP = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_TOTAL = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_IN_USE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEMS_PER_GROUP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_OFFSET    = 2'd2;

  // Register reset values
  localparam logic [GIU_W-1:0]    GIU_RST    = 5'd16;
  localparam logic [IPG_W-1:0]    IPG_RST    = 14'd8192;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 8'd1;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/gba_if.sv =====
// Channel interfaces of the allocator: request, result and register write.
// Depends on gba_pkg for field widths.
`default_nettype none

interface gba_in_if import gba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [GROUP_W-1:0]  group;
  logic [BIDX_W-1:0]   byte_index;
  logic [BYTE_W-1:0]   byte_value;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, func, group, byte_index, byte_value, count, input ready);
  modport sink   (input valid, func, group, byte_index, byte_value, count, output ready);
endinterface

interface gba_out_if import gba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] alloc_index;
  logic               status;

  modport source (output valid, alloc_index, status, input ready);
  modport sink   (input valid, alloc_index, status, output ready);
endinterface

interface gba_cfg_if import gba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/gba_bitmap_store.sv =====
// Usage bitmap memory: one write and one registered read port, plus the
// zeroing sweep that runs after reset. Depends on gba_pkg.
`default_nettype none

module gba_bitmap_store
  import gba_pkg::*;
#(
  parameter int ADDR_W = 14
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [BYTE_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [BYTE_W-1:0] rd_data,
  output logic                   busy
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = {ADDR_W{1'b1}};

  logic [BYTE_W-1:0] mem [2**ADDR_W];
  logic [BYTE_W-1:0] rd_data_r;
  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // Zeroing sweep control, one entry per cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) clr_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Memory array, sweep has the write port while busy
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

`default_nettype wire

// ===== hdl/grouped_bitmap_allocator_top.sv =====
// Grouped first-fit bitmap allocator top; uses gba_pkg, gba_if, gba_bitmap_store.
// One item at a time. Loads and zero-total allocates go straight to S_DONE; other
// allocates run S_GSEL (skipping zero-count groups), then S_BREQ/S_BCHK per byte
// (read, then test/update), refusing when groups or bytes run out. S_DONE waits
// for a free output slot. Reset: counts and registers clear at once, then a
// sweep zeroes all 2**(GW+BW) bitmap bytes (16384 by default); input not ready.
`default_nettype none

module grouped_bitmap_allocator_top
  import gba_pkg::*;
#(
  parameter int GROUPS       = GROUPS_DEF,
  parameter int BITMAP_BYTES = BITMAP_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gba_in_if.sink     in_ch,
  gba_out_if.source  out_ch,
  gba_cfg_if.sink    cfg_ch
);

  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int BW     = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int GCW    = $clog2(GROUPS + 1);
  localparam int BCW    = $clog2(BITMAP_BYTES + 1);
  localparam int ADDR_W = GW + BW;
  localparam int BASE_W = GCW + IPG_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GSEL = 3'd1;
  localparam logic [2:0] S_BREQ = 3'd2;
  localparam logic [2:0] S_BCHK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Lowest clear bit of a byte that is not full
  function automatic logic [2:0] first_zero(input logic [BYTE_W-1:0] v);
    logic [2:0] pos;
    pos = 3'd0;
    for (int j = BYTE_W - 1; j >= 0; j--) begin
      if (!v[j]) pos = 3'(j);
    end
    return pos;
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [GIU_W-1:0]    groups_in_use_r;
  logic [IPG_W-1:0]    items_per_group_r;
  logic [OFFSET_W-1:0] index_offset_r;
  logic [GFREE_W-1:0]  group_free_r [GROUPS];
  logic [TFREE_W-1:0]  total_free_r;
  logic [GCW-1:0]      g_r, g_nxt;
  logic [BCW-1:0]      b_r, b_nxt;
  logic [BASE_W-1:0]   base_r, base_nxt;
  logic [INDEX_W-1:0]  res_index_r, res_index_nxt;
  logic                res_status_r, res_status_nxt;
  logic                out_valid_r;
  logic [INDEX_W-1:0]  out_index_r;
  logic                out_status_r;

  logic                in_acc;
  logic                clr_busy;
  logic [BYTE_W-1:0]   rd_data;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [BYTE_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic                out_free;
  logic                in_group_ok;
  logic                in_byte_ok;
  logic                g_end;
  logic                b_end;
  logic                byte_full;
  logic [2:0]          bit_pos;
  logic [31:0]         idx_sum;
  logic                alloc_hit;
  logic [GW-1:0]       g_sel;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign g_sel     = g_r[GW-1:0];

  assign in_group_ok = 32'(in_ch.group) < 32'(GROUPS);
  assign in_byte_ok  = 32'(in_ch.byte_index) < 32'(BITMAP_BYTES);
  assign g_end = (32'(g_r) >= 32'(groups_in_use_r)) || (32'(g_r) >= 32'(GROUPS));
  assign b_end = (32'(b_r) >= 32'(items_per_group_r >> 3)) ||
                 (32'(b_r) >= 32'(BITMAP_BYTES));
  assign byte_full = (rd_data == BYTE_FULL);
  assign bit_pos   = first_zero(rd_data);
  assign idx_sum   = 32'(base_r) + 32'({b_r, bit_pos}) + 32'(index_offset_r);
  assign alloc_hit = (state_r == S_BCHK) && !byte_full;

  // Bitmap memory
  gba_bitmap_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rd_data (rd_data),
    .busy    (clr_busy)
  );

  assign mem_raddr = {g_sel, b_r[BW-1:0]};

  // Memory write: byte load at accept, or bit set on a hit
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mem_raddr;
    mem_wdata = rd_data | (BYTE_W'(1) << bit_pos);
    if (alloc_hit) begin
      mem_we = 1'b1;
    end else if (in_acc && in_ch.func == FUNC_LOAD_BYTE && in_group_ok && in_byte_ok) begin
      mem_we    = 1'b1;
      mem_waddr = {GW'(in_ch.group), BW'(in_ch.byte_index)};
      mem_wdata = in_ch.byte_value;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    g_nxt          = g_r;
    b_nxt          = b_r;
    base_nxt       = base_r;
    res_index_nxt  = res_index_r;
    res_status_nxt = res_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_index_nxt  = '0;
          res_status_nxt = STATUS_OK;
          g_nxt          = '0;
          state_nxt      = S_DONE;
          if (in_ch.func == FUNC_ALLOC) begin
            if (total_free_r == '0) res_status_nxt = STATUS_FAIL;
            else                    state_nxt      = S_GSEL;
          end
        end
      end
      S_GSEL: begin
        if (g_end) begin
          res_status_nxt = STATUS_FAIL;
          state_nxt      = S_DONE;
        end else if (group_free_r[g_sel] != '0) begin
          base_nxt  = BASE_W'(g_r) * BASE_W'(items_per_group_r);
          b_nxt     = '0;
          state_nxt = S_BREQ;
        end else begin
          g_nxt = GCW'(g_r + 1'b1);
        end
      end
      S_BREQ: begin
        if (b_end) begin
          res_status_nxt = STATUS_FAIL;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        if (byte_full) begin
          b_nxt     = BCW'(b_r + 1'b1);
          state_nxt = S_BREQ;
        end else begin
          res_index_nxt = idx_sum[INDEX_W-1:0];
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    g_r          <= g_nxt;
    b_r          <= b_nxt;
    base_r       <= base_nxt;
    res_index_r  <= res_index_nxt;
    res_status_r <= res_status_nxt;
  end

  // Free counts: loads and decrement on a hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_free_r <= '0;
      for (int i = 0; i < GROUPS; i++) group_free_r[i] <= '0;
    end else if (alloc_hit) begin
      total_free_r        <= total_free_r - 1'b1;
      group_free_r[g_sel] <= group_free_r[g_sel] - 1'b1;
    end else if (in_acc && in_group_ok) begin
      if (in_ch.func == FUNC_LOAD_GROUP) begin
        group_free_r[GW'(in_ch.group)] <=
          (in_ch.count > COUNT_W'(GROUP_FREE_MAX)) ? GROUP_FREE_MAX
                                                   : in_ch.count[GFREE_W-1:0];
      end else if (in_ch.func == FUNC_LOAD_TOTAL) begin
        total_free_r <= in_ch.count;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      groups_in_use_r   <= GIU_RST;
      items_per_group_r <= IPG_RST;
      index_offset_r    <= OFFSET_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_GROUPS_IN_USE:   groups_in_use_r   <= cfg_ch.data[GIU_W-1:0];
        CFG_ITEMS_PER_GROUP: items_per_group_r <= cfg_ch.data[IPG_W-1:0];
        CFG_INDEX_OFFSET:    index_offset_r    <= cfg_ch.data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_index_r  <= res_index_r;
      out_status_r <= res_status_r;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE) && !clr_busy;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.alloc_index = out_index_r;
  assign out_ch.status      = out_status_r;

  // Checks
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ch.ready)
    else $error("item accepted during bitmap sweep");

  a_fail_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_FAIL) |-> (out_index_r == '0))
    else $error("failed allocation with nonzero index");

  a_total_dec: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_hit |=> (total_free_r == TFREE_W'($past(total_free_r) - 1'b1)))
    else $error("total free count not decremented on allocation");

  a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BREQ || state_r == S_BCHK) |-> (32'(g_r) < 32'(GROUPS)))
    else $error("scan group out of range");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_free) |=> (state_r == S_DONE))
    else $error("result dropped while output busy");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for grouped_bitmap_allocator_top: directed and random requests whose
// results are checked against an in-bench model of the bitmaps and free counts.
// Depends on gba_pkg, the channel interfaces in gba_if.sv and the top level.
`timescale 1ns / 1ps

module testbench;
  import gba_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int LIMIT_CYCLES = 4_000_000;  // reset sweep plus ~600 worst-case scans, x3
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 2100;      // one worst-case allocate scan
  localparam int PHASE_ITEMS  = 88;
  localparam int NUM_PHASES   = 6;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [GROUP_W-1:0] group;
    logic [BIDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0]  byte_value;
    logic [COUNT_W-1:0] count;
  } alloc_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] alloc_index;
    logic               status;
  } alloc_resp_t;

  // Scoreboard: mirrors the allocator state and queues the expected grants
  class alloc_scoreboard;
    logic [BYTE_W-1:0]   bitmap [GROUPS_DEF][BITMAP_BYTES_DEF];
    logic [GFREE_W-1:0]  group_free [GROUPS_DEF];
    logic [TFREE_W-1:0]  total_free;
    logic [GIU_W-1:0]    groups_in_use;
    logic [IPG_W-1:0]    items_per_group;
    logic [OFFSET_W-1:0] index_offset;
    alloc_resp_t         expected_grants [$];
    int n_requests;
    int n_allocs;
    int n_refused;
    int n_errors;

    function new();
      foreach (bitmap[g, b]) bitmap[g][b] = '0;
      foreach (group_free[g]) group_free[g] = '0;
      total_free      = '0;
      groups_in_use   = GIU_RST;
      items_per_group = IPG_RST;
      index_offset    = OFFSET_RST;
      n_requests = 0;
      n_allocs   = 0;
      n_refused  = 0;
      n_errors   = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GROUPS_IN_USE:   groups_in_use   = data[GIU_W-1:0];
        CFG_ITEMS_PER_GROUP: items_per_group = data[IPG_W-1:0];
        CFG_INDEX_OFFSET:    index_offset    = data[OFFSET_W-1:0];
        default: ;
      endcase
    endfunction

    // First fit: lowest searched group with a nonzero count, first clear bit
    // among its whole bytes; a miss there refuses without trying later groups
    function alloc_resp_t first_fit();
      alloc_resp_t r;
      int ngroups, nbytes, g, b, j, pos;
      r.alloc_index = '0;
      r.status      = STATUS_FAIL;
      if (total_free == 0) return r;
      ngroups = (groups_in_use > GROUPS_DEF) ? GROUPS_DEF : groups_in_use;
      nbytes  = items_per_group / 8;
      if (nbytes > BITMAP_BYTES_DEF) nbytes = BITMAP_BYTES_DEF;
      for (g = 0; g < ngroups; g++) begin
        if (group_free[g] == 0) continue;
        for (b = 0; b < nbytes; b++) begin
          if (bitmap[g][b] == BYTE_FULL) continue;
          for (j = 0; j < 8; j++) begin
            if (!bitmap[g][b][j]) begin
              bitmap[g][b][j] = 1'b1;
              group_free[g]   = group_free[g] - 1'b1;
              total_free      = total_free - 1'b1;
              pos = g * items_per_group + b * 8 + j + index_offset;
              r.alloc_index = pos[INDEX_W-1:0];
              r.status      = STATUS_OK;
              return r;
            end
          end
        end
        return r;
      end
      return r;
    endfunction

    function void note_request(alloc_req_t req);
      alloc_resp_t r;
      r.alloc_index = '0;
      r.status      = STATUS_OK;
      n_requests++;
      if (req.func == FUNC_ALLOC) begin
        r = first_fit();
        n_allocs++;
        if (r.status == STATUS_FAIL) n_refused++;
      end else if (req.group < GROUPS_DEF) begin
        case (req.func)
          FUNC_LOAD_BYTE:
            if (req.byte_index < BITMAP_BYTES_DEF)
              bitmap[req.group][req.byte_index] = req.byte_value;
          FUNC_LOAD_GROUP:
            group_free[req.group] = (req.count > GROUP_FREE_MAX) ? GROUP_FREE_MAX
                                                                 : req.count[GFREE_W-1:0];
          FUNC_LOAD_TOTAL:
            total_free = req.count;
          default: ;
        endcase
      end
      expected_grants.push_back(r);
    endfunction

    function void check_grant(alloc_resp_t got);
      alloc_resp_t want;
      if (expected_grants.size() == 0) begin
        $error("unexpected result: alloc_index %0d status %0d", got.alloc_index, got.status);
        n_errors++;
        return;
      end
      want = expected_grants.pop_front();
      if (got.alloc_index !== want.alloc_index) begin
        $error("alloc_index mismatch: expected %0d, actual %0d",
               want.alloc_index, got.alloc_index);
        n_errors++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  gba_in_if  in_ch ();
  gba_out_if out_ch ();
  gba_cfg_if cfg_ch ();

  grouped_bitmap_allocator_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  alloc_scoreboard sb;
  int send_idle_pct = 28;
  int recv_idle_pct = 55;
  bit recv_hold_req = 1'b0;
  int n_settings = 0;
  alloc_req_t  seen_req;
  alloc_resp_t seen_resp;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Observe every handshake at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_register(cfg_ch.index, cfg_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        seen_resp.alloc_index = out_ch.alloc_index;
        seen_resp.status      = out_ch.status;
        sb.check_grant(seen_resp);
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_req.func       = in_ch.func;
        seen_req.group      = in_ch.group;
        seen_req.byte_index = in_ch.byte_index;
        seen_req.byte_value = in_ch.byte_value;
        seen_req.count      = in_ch.count;
        sb.note_request(seen_req);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        recv_hold_req = 1'b0;
      end
      out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
    $display("simulation failed");
    $finish;
  end

  // Offer one item; returns at the falling edge after it is taken
  task automatic send_request(input alloc_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.func       = req.func;
    in_ch.group      = req.group;
    in_ch.byte_index = req.byte_index;
    in_ch.byte_value = req.byte_value;
    in_ch.count      = req.count;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic alloc_req_t random_req();
    alloc_req_t req;
    req.func       = FUNC_W'($urandom);
    req.group      = GROUP_W'($urandom);
    req.byte_index = BIDX_W'($urandom);
    req.byte_value = BYTE_W'($urandom);
    req.count      = COUNT_W'($urandom);
    return req;
  endfunction

  // Unused fields of each operation carry random values
  task automatic send_alloc();
    alloc_req_t req;
    req = random_req();
    req.func = FUNC_ALLOC;
    send_request(req);
  endtask

  task automatic load_byte(input int g, input int idx, input int val);
    alloc_req_t req;
    req = random_req();
    req.func       = FUNC_LOAD_BYTE;
    req.group      = GROUP_W'(g);
    req.byte_index = BIDX_W'(idx);
    req.byte_value = BYTE_W'(val);
    send_request(req);
  endtask

  task automatic load_group(input int g, input int cnt);
    alloc_req_t req;
    req = random_req();
    req.func  = FUNC_LOAD_GROUP;
    req.group = GROUP_W'(g);
    req.count = COUNT_W'(cnt);
    send_request(req);
  endtask

  task automatic load_total(input int cnt);
    alloc_req_t req;
    req = random_req();
    req.func  = FUNC_LOAD_TOTAL;
    req.count = COUNT_W'(cnt);
    send_request(req);
  endtask

  // Stop offering and wait until every grant is back
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Registers change only with the block idle; upper data bits are junk
  task automatic apply_setting(input int giu, input int ipg, input int offset);
    wait_drained();
    cfg_write(CFG_GROUPS_IN_USE, CFG_DATA_W'(($urandom_range(0, 511) << GIU_W) | giu));
    cfg_write(CFG_ITEMS_PER_GROUP, CFG_DATA_W'(ipg));
    cfg_write(CFG_INDEX_OFFSET, CFG_DATA_W'(($urandom_range(0, 63) << OFFSET_W) | offset));
    n_settings++;
  endtask

  // Mostly groups that are searched, sometimes any group
  function automatic int pick_group();
    int span;
    span = (sb.groups_in_use == 0 || sb.groups_in_use > GROUPS_DEF) ? GROUPS_DEF
                                                                   : sb.groups_in_use;
    if ($urandom_range(99) < 80) return $urandom_range(0, span - 1);
    return $urandom_range(0, GROUPS_DEF - 1);
  endfunction

  // Mostly bytes near the front of the scan, where they matter
  function automatic int pick_byte_index();
    int span;
    span = sb.items_per_group / 8;
    if (span > 8) span = 8;
    if (span < 1) span = 1;
    if ($urandom_range(99) < 90) return $urandom_range(0, span - 1);
    return $urandom_range(0, BITMAP_BYTES_DEF - 1);
  endfunction

  function automatic int pick_byte_value();
    int r;
    r = $urandom_range(9);
    if (r < 4) return BYTE_FULL;
    if (r < 6) return 0;
    return $urandom_range(0, 255);
  endfunction

  // Random part: load-then-allocate sequences, with random items as noise
  task automatic run_random_phase(input int n_items, input int hold_at, input int drain_at);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if (hold_at >= 0 && sent >= hold_at) begin
        recv_hold_req = 1'b1;
        hold_at = -1;
      end
      if (drain_at >= 0 && sent >= drain_at) begin
        wait_drained();
        drain_at = -1;
      end
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(1)) begin
          load_total(($urandom_range(9) == 0) ? $urandom_range(0, (1 << COUNT_W) - 1)
                                              : $urandom_range(1, 60));
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          load_group(pick_group(), ($urandom_range(9) == 0)
                                   ? $urandom_range(0, (1 << COUNT_W) - 1)
                                   : $urandom_range(0, 20));
          sent++;
        end
        repeat ($urandom_range(0, 3)) begin
          load_byte(pick_group(), pick_byte_index(), pick_byte_value());
          sent++;
        end
        repeat ($urandom_range(1, 6)) begin
          send_alloc();
          sent++;
        end
      end else begin
        send_request(random_req());
        sent++;
      end
    end
  endtask

  initial begin
    int p;
    int ph_giu [NUM_PHASES];
    int ph_ipg [NUM_PHASES];
    int ph_off [NUM_PHASES];
    ph_giu = '{16, 1, 31, 16, 3, 0};
    ph_ipg = '{8192, 8, 16383, 64, 13, 0};
    ph_off = '{1, 0, 255, 255, 7, 0};
    ph_giu[NUM_PHASES-1] = $urandom_range(1, 16);
    ph_ipg[NUM_PHASES-1] = $urandom_range(8, 400);
    ph_off[NUM_PHASES-1] = $urandom_range(0, 255);

    sb = new();
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_ALLOC;
    in_ch.group      = '0;
    in_ch.byte_index = '0;
    in_ch.byte_value = '0;
    in_ch.count      = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_GROUPS_IN_USE;
    cfg_ch.data      = '0;
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset register values first
    send_alloc();                 // total is zero
    load_total(5);
    send_alloc();                 // total set but no group count
    load_group(3, 18'h3ffff);     // saturates
    load_byte(3, 0, BYTE_FULL);
    load_byte(3, 1, 8'hf7);
    send_alloc();                 // full byte skipped, hole in the next one
    load_group(0, 1);
    load_byte(0, 0, BYTE_FULL);
    send_alloc();
    send_alloc();                 // group 0 now empty, moves on to group 3
    load_byte(15, BITMAP_BYTES_DEF - 1, 8'h00);
    load_byte(7, BITMAP_BYTES_DEF - 1, BYTE_FULL);
    load_total((1 << COUNT_W) - 1);

    // No groups searched at all
    apply_setting(0, 13, 255);
    send_alloc();

    // More groups than exist, partial last byte
    apply_setting(31, 13, 0);
    send_alloc();                 // group 3 first, its only byte is full: refused
    load_group(3, 0);
    load_group(15, 2);
    load_byte(15, 0, 8'h7f);
    send_alloc();
    send_alloc();                 // count left but no clear bit in range

    // Scan length capped by the bitmap size, widest index
    apply_setting(16, 16383, 255);
    load_byte(15, 0, 8'h00);
    send_alloc();

    // Fewer than eight items per group: nothing to scan
    apply_setting(16, 7, 9);
    load_group(0, 3);
    send_alloc();

    // Random phases under three idling patterns
    for (p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = (p < 2) ? 28 : (p < 4) ? 55 : 0;
      recv_idle_pct = (p < 2) ? 55 : (p < 4) ? 28 : 0;
      apply_setting(ph_giu[p], ph_ipg[p], ph_off[p]);
      run_random_phase(PHASE_ITEMS, (p == 4) ? 30 : -1, (p == 2) ? 40 : -1);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Checked %0d requests, %0d of them allocations (%0d refused), over %0d settings.",
             sb.n_requests, sb.n_allocs, sb.n_refused, n_settings);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
